FILE: design/ssi_pkg.sv
// ----------------------------------------------------------------------------
// ssi_pkg
// Shared widths, payload structs and register codes for the segment / sphere
// intersection block.
// ----------------------------------------------------------------------------
package ssi_pkg;

	localparam int COORD_W    = 32;
	localparam int FRAC_BITS  = 16;
	localparam int RADIUS_W   = COORD_W - 1;
	localparam int RADIUS_RST = 1 << FRAC_BITS;

	localparam int DELTA_W = COORD_W + 1;       // new - old, old - center
	localparam int SQ_W    = 2 * COORD_W;       // one squared delta
	localparam int A_W     = SQ_W + 2;          // d.d
	localparam int H_W     = SQ_W + 3;          // d.w and w.w - r*r, signed
	localparam int HALF_W  = A_W / 2;           // limb of the wide multiply
	localparam int WIDE_W  = 2 * A_W;           // H*H and A*C magnitudes
	localparam int DISC_W  = WIDE_W + 2;        // signed discriminant
	localparam int RAD_W   = 2 * SQ_W;          // non-negative discriminant
	localparam int ROOT_W  = SQ_W;              // floor(sqrt(D))
	localparam int REM_W   = ROOT_W + 4;        // sqrt partial remainder
	localparam int NUM_W   = H_W + 2;           // -H +/- S
	localparam int P_W     = A_W + COORD_W;     // num * |d|
	localparam int Q_W     = COORD_W + 1;       // quotient bits
	localparam int DREM_W  = A_W + 1;           // divider partial remainder

	localparam int SQRT_CELLS = ROOT_W;
	localparam int DIV_CELLS  = Q_W;
	localparam int REG_IDX_W  = 2;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DELTA_W-1:0] delta_t;

	typedef struct packed {
		coord_t new_x;
		coord_t new_y;
		coord_t new_z;
		coord_t old_x;
		coord_t old_y;
		coord_t old_z;
	} in_t;

	typedef struct packed {
		coord_t point_x;
		coord_t point_y;
		coord_t point_z;
		logic   hit;
	} out_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_CENTER_X = 2'd0,
		REG_CENTER_Y = 2'd1,
		REG_CENTER_Z = 2'd2,
		REG_RADIUS   = 2'd3
	} reg_idx_t;

	// travels beside the square root chain
	typedef struct packed {
		logic                    ok;
		logic [A_W-1:0]          a;
		logic signed [H_W-1:0]   h;
		coord_t [2:0]            old;
		delta_t [2:0]            d;
	} sq_side_t;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
		logic [RAD_W-1:0]  rad;
	} sq_data_t;

	// travels beside the divider chain
	typedef struct packed {
		logic           hit;
		logic [A_W-1:0] a;
		coord_t [2:0]   old;
		delta_t [2:0]   d;
	} div_side_t;

	typedef struct packed {
		logic [DREM_W-1:0] rem;
		logic [Q_W-1:0]    quo;
	} div_lane_t;

endpackage

FILE: design/ssi_sqrt_cell.sv
// ----------------------------------------------------------------------------
// ssi_sqrt_cell
// One bit of a digit-by-digit integer square root; passes its sideband along.
// ----------------------------------------------------------------------------
module ssi_sqrt_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              v_in,
	input  ssi_pkg::sq_side_t side_in,
	input  ssi_pkg::sq_data_t dat_in,
	output logic              v_out,
	output ssi_pkg::sq_side_t side_out,
	output ssi_pkg::sq_data_t dat_out
);
	import ssi_pkg::*;

	logic [REM_W-1:0] r4;
	logic [REM_W-1:0] trial;
	logic             ge;
	sq_data_t         nxt;
	logic             v_s1;
	sq_side_t         side_s1;
	sq_data_t         dat_s1;

	always_comb begin
		r4      = {dat_in.rem[REM_W-3:0], dat_in.rad[RAD_W-1 -: 2]};
		trial   = REM_W'({dat_in.root, 2'b01});
		ge      = (r4 >= trial);
		nxt.rem  = ge ? (r4 - trial) : r4;
		nxt.root = {dat_in.root[ROOT_W-2:0], ge};
		nxt.rad  = {dat_in.rad[RAD_W-3:0], 2'b00};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= side_in;
			dat_s1  <= nxt;
		end
	end

	assign v_out    = v_s1;
	assign side_out = side_s1;
	assign dat_out  = dat_s1;

endmodule

FILE: design/ssi_div_cell.sv
// ----------------------------------------------------------------------------
// ssi_div_cell
// One quotient bit of a restoring divide, three axes side by side.
// ----------------------------------------------------------------------------
module ssi_div_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic                      v_in,
	input  ssi_pkg::div_side_t        side_in,
	input  ssi_pkg::div_lane_t [2:0]  lane_in,
	output logic                      v_out,
	output ssi_pkg::div_side_t        side_out,
	output ssi_pkg::div_lane_t [2:0]  lane_out
);
	import ssi_pkg::*;

	div_lane_t [2:0] nxt;
	logic            v_s1;
	div_side_t       side_s1;
	div_lane_t [2:0] lane_s1;

	always_comb begin
		logic [DREM_W-1:0] r2;
		logic [DREM_W-1:0] dv;
		logic              ge;
		dv = DREM_W'(side_in.a);
		for (int i = 0; i < 3; i++) begin
			r2 = {lane_in[i].rem[DREM_W-2:0], lane_in[i].quo[Q_W-1]};
			ge = (r2 >= dv);
			nxt[i].rem = ge ? (r2 - dv) : r2;
			nxt[i].quo = {lane_in[i].quo[Q_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= side_in;
			lane_s1 <= nxt;
		end
	end

	assign v_out    = v_s1;
	assign side_out = side_s1;
	assign lane_out = lane_s1;

endmodule

FILE: design/ssi_prep.sv
// ----------------------------------------------------------------------------
// ssi_prep
// Front pipeline: deltas, dot products and the quarter discriminant.
// ----------------------------------------------------------------------------
module ssi_prep (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          in_v,
	input  ssi_pkg::in_t                  in_data,
	input  ssi_pkg::coord_t [2:0]         center,
	input  logic [ssi_pkg::RADIUS_W-1:0]  radius,
	output logic                          out_v,
	output ssi_pkg::sq_side_t             side,
	output ssi_pkg::sq_data_t             dat
);
	import ssi_pkg::*;

	typedef logic signed [2*DELTA_W-1:0] prod_t;

	coord_t [2:0] nw;
	coord_t [2:0] od;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	coord_t [2:0] old_s1, old_s2, old_s3, old_s4, old_s5, old_s6, old_s7;
	delta_t [2:0] d_s1, d_s2, d_s3, d_s4, d_s5, d_s6, d_s7;

	delta_t [2:0] w_s1;
	prod_t [2:0]  dd_s2, dw_s2, ww_s2;
	logic [2*RADIUS_W-1:0] rr_s2;

	logic [A_W-1:0]        a_s3;
	logic signed [H_W-1:0] h_s3, c_s3;

	logic [A_W-1:0]        a_s4, hm_s4, cm_s4;
	logic signed [H_W-1:0] h_s4;
	logic                  cneg_s4;

	logic [2*HALF_W-1:0]   hh00_s5, hh01_s5, hh11_s5;
	logic [2*HALF_W-1:0]   ac00_s5, ac01_s5, ac10_s5, ac11_s5;
	logic [A_W-1:0]        a_s5;
	logic signed [H_W-1:0] h_s5;
	logic                  cneg_s5;

	logic [WIDE_W-1:0]     hh_s6, acm_s6;
	logic [A_W-1:0]        a_s6;
	logic signed [H_W-1:0] h_s6;
	logic                  cneg_s6;

	logic [A_W-1:0]        a_s7;
	logic signed [H_W-1:0] h_s7;
	logic                  ok_s7;
	logic [RAD_W-1:0]      rad_s7;

	logic signed [H_W-1:0] a_sum, h_sum, c_sum, h_neg, c_neg;
	logic [DISC_W-1:0]     disc;

	assign nw = {in_data.new_z, in_data.new_y, in_data.new_x};
	assign od = {in_data.old_z, in_data.old_y, in_data.old_x};

	always_comb begin
		a_sum = H_W'($signed(dd_s2[0])) + H_W'($signed(dd_s2[1]))
			+ H_W'($signed(dd_s2[2]));
		h_sum = H_W'($signed(dw_s2[0])) + H_W'($signed(dw_s2[1]))
			+ H_W'($signed(dw_s2[2]));
		c_sum = H_W'($signed(ww_s2[0])) + H_W'($signed(ww_s2[1]))
			+ H_W'($signed(ww_s2[2])) - H_W'(rr_s2);
		h_neg = -h_s3;
		c_neg = -c_s3;
		// C < 0 flips the sign of A*C
		if (cneg_s6) begin
			disc = {2'b00, hh_s6} + {2'b00, acm_s6};
		end else begin
			disc = {2'b00, hh_s6} - {2'b00, acm_s6};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// s1: d = new - old, w = old - center
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= DELTA_W'($signed(nw[i])) - DELTA_W'($signed(od[i]));
				w_s1[i] <= DELTA_W'($signed(od[i])) - DELTA_W'($signed(center[i]));
			end
			old_s1 <= od;

			// s2: per-axis products
			for (int i = 0; i < 3; i++) begin
				dd_s2[i] <= $signed(d_s1[i]) * $signed(d_s1[i]);
				dw_s2[i] <= $signed(d_s1[i]) * $signed(w_s1[i]);
				ww_s2[i] <= $signed(w_s1[i]) * $signed(w_s1[i]);
			end
			rr_s2  <= radius * radius;
			old_s2 <= old_s1;
			d_s2   <= d_s1;

			// s3: A, H, C
			a_s3   <= a_sum[A_W-1:0];
			h_s3   <= h_sum;
			c_s3   <= c_sum;
			old_s3 <= old_s2;
			d_s3   <= d_s2;

			// s4: magnitudes for the wide multiply
			a_s4    <= a_s3;
			h_s4    <= h_s3;
			hm_s4   <= h_s3[H_W-1] ? h_neg[A_W-1:0] : h_s3[A_W-1:0];
			cm_s4   <= c_s3[H_W-1] ? c_neg[A_W-1:0] : c_s3[A_W-1:0];
			cneg_s4 <= c_s3[H_W-1];
			old_s4  <= old_s3;
			d_s4    <= d_s3;

			// s5: limb products
			hh00_s5 <= hm_s4[HALF_W-1:0] * hm_s4[HALF_W-1:0];
			hh01_s5 <= hm_s4[HALF_W-1:0] * hm_s4[A_W-1:HALF_W];
			hh11_s5 <= hm_s4[A_W-1:HALF_W] * hm_s4[A_W-1:HALF_W];
			ac00_s5 <= a_s4[HALF_W-1:0] * cm_s4[HALF_W-1:0];
			ac01_s5 <= a_s4[HALF_W-1:0] * cm_s4[A_W-1:HALF_W];
			ac10_s5 <= a_s4[A_W-1:HALF_W] * cm_s4[HALF_W-1:0];
			ac11_s5 <= a_s4[A_W-1:HALF_W] * cm_s4[A_W-1:HALF_W];
			a_s5    <= a_s4;
			h_s5    <= h_s4;
			cneg_s5 <= cneg_s4;
			old_s5  <= old_s4;
			d_s5    <= d_s4;

			// s6: recombine limbs
			hh_s6  <= WIDE_W'(hh00_s5) + (WIDE_W'(hh01_s5) << (HALF_W + 1))
				+ (WIDE_W'(hh11_s5) << (2 * HALF_W));
			acm_s6 <= WIDE_W'(ac00_s5)
				+ ((WIDE_W'(ac01_s5) + WIDE_W'(ac10_s5)) << HALF_W)
				+ (WIDE_W'(ac11_s5) << (2 * HALF_W));
			a_s6    <= a_s5;
			h_s6    <= h_s5;
			cneg_s6 <= cneg_s5;
			old_s6  <= old_s5;
			d_s6    <= d_s5;

			// s7: D = H*H - A*C; zero radicand on a miss
			ok_s7  <= (a_s6 != '0) && !disc[DISC_W-1];
			rad_s7 <= ((a_s6 != '0) && !disc[DISC_W-1]) ? disc[RAD_W-1:0] : '0;
			a_s7   <= a_s6;
			h_s7   <= h_s6;
			old_s7 <= old_s6;
			d_s7   <= d_s6;
		end
	end

	assign out_v     = v_s7;
	assign side.ok   = ok_s7;
	assign side.a    = a_s7;
	assign side.h    = h_s7;
	assign side.old  = old_s7;
	assign side.d    = d_s7;
	assign dat.rem   = '0;
	assign dat.root  = '0;
	assign dat.rad   = rad_s7;

endmodule

FILE: design/segment_sphere_intersection.sv
// ----------------------------------------------------------------------------
// segment_sphere_intersection
// Finds where a segment old->new meets a configured sphere (the later crossing
// if both lie in [0,1]) and returns it, or the new point if none lies in [0,1].
// ----------------------------------------------------------------------------
//
//  channel   signals                          direction  payload
//  -------   -------------------------------  ---------  -----------------------
//  input     in_valid / in_stall / in_data    in         old and new point, Q16.16
//  output    out_valid / out_stall / out_data out        point and hit flag
//  config    cfg_we / cfg_index / cfg_data    in         center x,y,z and radius
//
//  One transaction per clock sustained while the output buffer has room. The
//  path from input to output register runs through 7 front stages, 64
//  square-root cells (one root bit each), 3 stages of root select and
//  scaling, 33 divider cells (one quotient bit each), then the output register.
//  Reset clears all valid bits; the config registers reset to center 0 and
//  radius 1.0. A two-entry output buffer (output register plus skid entry)
//  absorbs out_stall; in_stall rises only when both entries are full, and
//  then the whole pipeline holds.
//
module segment_sphere_intersection (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  ssi_pkg::in_t                    in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output ssi_pkg::out_t                   out_data,
	input  logic                            cfg_we,
	input  logic [ssi_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [ssi_pkg::COORD_W-1:0]     cfg_data
);
	import ssi_pkg::*;

	// configuration
	coord_t [2:0]          center_q;
	logic [RADIUS_W-1:0]   radius_q;

	// pipeline advance: held only while the output buffer is full
	logic adv;

	// square root chain
	logic     [SQRT_CELLS:0] sq_v;
	sq_side_t sq_side [SQRT_CELLS+1];
	sq_data_t sq_dat  [SQRT_CELLS+1];

	// root select (s1), scale multiply (s2), product sum (s3)
	logic [NUM_W-1:0] nh, n1, n2;
	logic             acc1, acc2;
	logic             v_s1, hit_s1;
	logic [A_W-1:0]   num_s1, a_s1;
	coord_t [2:0]     old_s1;
	delta_t [2:0]     d_s1;

	logic [COORD_W-1:0]        dm [3];
	delta_t                    dn;
	logic                      v_s2, hit_s2;
	logic [A_W-1:0]            a_s2;
	coord_t [2:0]              old_s2;
	delta_t [2:0]              d_s2;
	logic [HALF_W+COORD_W-1:0] pl_s2 [3];
	logic [HALF_W+COORD_W-1:0] ph_s2 [3];

	logic [P_W-1:0]  prod [3];
	logic            v_s3;
	div_side_t       side_s3;
	div_lane_t [2:0] lane_s3;

	// divider chain
	logic      [DIV_CELLS:0] dv_v;
	div_side_t               dv_side [DIV_CELLS+1];
	div_lane_t [2:0]         dv_lane [DIV_CELLS+1];

	// output buffer
	coord_t [2:0] pt;
	out_t         push_data;
	logic         push, pop;
	out_t         head_q, skid_q;
	logic         head_v_q, skid_v_q;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= '0;
			radius_q <= RADIUS_W'(RADIUS_RST);
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_CENTER_X: center_q[0] <= cfg_data;
				REG_CENTER_Y: center_q[1] <= cfg_data;
				REG_CENTER_Z: center_q[2] <= cfg_data;
				REG_RADIUS:   radius_q    <= cfg_data[RADIUS_W-1:0];
			endcase
		end
	end

	assign adv      = !skid_v_q;
	assign in_stall = skid_v_q;

	// ----------------------------------------------------------- front end
	ssi_prep u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_v    (in_valid),
		.in_data (in_data),
		.center  (center_q),
		.radius  (radius_q),
		.out_v   (sq_v[0]),
		.side    (sq_side[0]),
		.dat     (sq_dat[0])
	);

	// -------------------------------------------- floor(sqrt(D)), MSB first
	for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_sqrt
		ssi_sqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.v_in     (sq_v[g]),
			.side_in  (sq_side[g]),
			.dat_in   (sq_dat[g]),
			.v_out    (sq_v[g+1]),
			.side_out (sq_side[g+1]),
			.dat_out  (sq_dat[g+1])
		);
	end

	// --------------------------------------------------------- root select
	// Larger root numerator -H+S tried first, then -H-S; accepted if 0<=N<=A.
	always_comb begin
		nh   = -{{(NUM_W-H_W){sq_side[SQRT_CELLS].h[H_W-1]}}, sq_side[SQRT_CELLS].h};
		n1   = nh + NUM_W'(sq_dat[SQRT_CELLS].root);
		n2   = nh - NUM_W'(sq_dat[SQRT_CELLS].root);
		acc1 = !n1[NUM_W-1] && (n1 <= NUM_W'(sq_side[SQRT_CELLS].a));
		acc2 = !n2[NUM_W-1] && (n2 <= NUM_W'(sq_side[SQRT_CELLS].a));
	end

	// |d| per axis for the scale multiply
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dn    = -d_s1[i];
			dm[i] = d_s1[i][DELTA_W-1] ? dn[COORD_W-1:0] : d_s1[i][COORD_W-1:0];
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			prod[i] = P_W'(pl_s2[i]) + (P_W'(ph_s2[i]) << HALF_W);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= sq_v[SQRT_CELLS];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// s1
			hit_s1 <= sq_side[SQRT_CELLS].ok && (acc1 || acc2);
			num_s1 <= acc1 ? n1[A_W-1:0] : n2[A_W-1:0];
			a_s1   <= sq_side[SQRT_CELLS].a;
			old_s1 <= sq_side[SQRT_CELLS].old;
			d_s1   <= sq_side[SQRT_CELLS].d;
			// s2: N * |d| as two limb products
			for (int i = 0; i < 3; i++) begin
				pl_s2[i] <= num_s1[HALF_W-1:0] * dm[i];
				ph_s2[i] <= num_s1[A_W-1:HALF_W] * dm[i];
			end
			hit_s2 <= hit_s1;
			a_s2   <= a_s1;
			old_s2 <= old_s1;
			d_s2   <= d_s1;
			// s3: load the divider; the high part is already below A
			for (int i = 0; i < 3; i++) begin
				lane_s3[i].rem <= DREM_W'(prod[i][P_W-1:Q_W]);
				lane_s3[i].quo <= prod[i][Q_W-1:0];
			end
			side_s3.hit <= hit_s2;
			side_s3.a   <= a_s2;
			side_s3.old <= old_s2;
			side_s3.d   <= d_s2;
		end
	end

	assign dv_v[0]    = v_s3;
	assign dv_side[0] = side_s3;
	assign dv_lane[0] = lane_s3;

	// ------------------------------------------- |N*d| / A, one bit a cell
	for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
		ssi_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.v_in     (dv_v[g]),
			.side_in  (dv_side[g]),
			.lane_in  (dv_lane[g]),
			.v_out    (dv_v[g+1]),
			.side_out (dv_side[g+1]),
			.lane_out (dv_lane[g+1])
		);
	end

	// ---------------------------------------------------------- final point
	// Negative products floor toward minus infinity: add one on a remainder.
	always_comb begin
		logic [COORD_W-1:0] mag;
		for (int i = 0; i < 3; i++) begin
			mag = COORD_W'(dv_lane[DIV_CELLS][i].quo)
				+ COORD_W'(|dv_lane[DIV_CELLS][i].rem);
			if (!dv_side[DIV_CELLS].hit) begin
				pt[i] = dv_side[DIV_CELLS].old[i]
					+ dv_side[DIV_CELLS].d[i][COORD_W-1:0];
			end else if (dv_side[DIV_CELLS].d[i][DELTA_W-1]) begin
				pt[i] = dv_side[DIV_CELLS].old[i] - mag;
			end else begin
				pt[i] = dv_side[DIV_CELLS].old[i]
					+ COORD_W'(dv_lane[DIV_CELLS][i].quo);
			end
		end
		push_data.point_x = pt[0];
		push_data.point_y = pt[1];
		push_data.point_z = pt[2];
		push_data.hit     = dv_side[DIV_CELLS].hit;
	end

	// -------------------------------------------------------- output buffer
	assign push = adv && dv_v[DIV_CELLS];
	assign pop  = head_v_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			if (skid_v_q) begin
				skid_v_q <= push;
			end else begin
				head_v_q <= push;
			end
		end else if (push) begin
			if (head_v_q) begin
				skid_v_q <= 1'b1;
			end else begin
				head_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_v_q) begin
				head_q <= skid_q;
				if (push) begin
					skid_q <= push_data;
				end
			end else if (push) begin
				head_q <= push_data;
			end
		end else if (push) begin
			if (head_v_q) begin
				skid_q <= push_data;
			end else begin
				head_q <= push_data;
			end
		end
	end

	assign out_valid = head_v_q;
	assign out_data  = head_q;

endmodule
